@@ hdl/gnpc_pkg.sv @@
// ----------------------------------------------------------------------------
// gnpc_pkg
// Shared types and codes for the greedy nearest point chain block.
// ----------------------------------------------------------------------------
package gnpc_pkg;

  localparam int REQ_W  = 2;
  localparam int XY_W   = 12;
  localparam int RANK_W = 8;
  localparam int IDXO_W = 8;
  localparam int STS_W  = 2;

  localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_NEW  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ADD  = 2'd2;

  localparam logic [STS_W-1:0] STS_OK    = 2'd0;
  localparam logic [STS_W-1:0] STS_EMPTY = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL  = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [XY_W-1:0]   point_x;
    logic [XY_W-1:0]   point_y;
    logic [RANK_W-1:0] random_rank;
  } in_req_t;

  typedef struct packed {
    logic [XY_W-1:0]   chosen_x;
    logic [XY_W-1:0]   chosen_y;
    logic [IDXO_W-1:0] chosen_index;
    logic [STS_W-1:0]  status;
  } out_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic scan;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

@@ hdl/gnpc_ram.sv @@
// ----------------------------------------------------------------------------
// gnpc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module gnpc_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/gnpc_ctrl.sv @@
// ----------------------------------------------------------------------------
// gnpc_ctrl
// Request sequencer: accepts one request, runs the store scan for add
// requests, then commits the result into the output register.
// ----------------------------------------------------------------------------
module gnpc_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [gnpc_pkg::REQ_W-1:0] req_type,
  input  gnpc_pkg::dp_sts_t       sts,
  output gnpc_pkg::dp_cmd_t       cmd
);
  import gnpc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = (req_type == REQ_ADD) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/gnpc_dp.sv @@
// ----------------------------------------------------------------------------
// gnpc_dp
// Point store, pipelined distance unit and rank counter, result register.
// ----------------------------------------------------------------------------
module gnpc_dp #(
  parameter int MAX_POINTS = 256,
  parameter int COORD_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gnpc_pkg::in_req_t  in_data,
  input  gnpc_pkg::dp_cmd_t  cmd,
  output gnpc_pkg::dp_sts_t  sts,
  output logic               out_valid,
  input  logic               out_stall,
  output gnpc_pkg::out_res_t out_data
);
  import gnpc_pkg::*;

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int WORD_W = 2 * COORD_BITS + 1;
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int D_W    = SQ_W + 1;
  localparam int RK_W   = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  // request registers
  logic [REQ_W-1:0]      req_r;
  logic [COORD_BITS-1:0] px_r, py_r;
  logic [RANK_W-1:0]     rank_r;

  // architectural state
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  chain_r, chain_nxt;
  logic [COORD_BITS-1:0] last_x_r, last_x_nxt, last_y_r, last_y_nxt;

  // scan pipeline
  logic [CNT_W-1:0]      scan_addr_r;
  logic                  rd_go;
  logic                  v1_r, v2_r;
  logic [IDX_W-1:0]      idx1_r, idx2_r;
  logic [WORD_W-1:0]     rd_data;
  logic [COORD_BITS-1:0] rx, ry, dx, dy, x2_r, y2_r;
  logic                  ru, u2_r;
  logic [SQ_W-1:0]       sqx_r, sqy_r;
  logic [D_W-1:0]        dsum;
  logic                  take, hit;

  // selection
  logic [RK_W-1:0]       seen_r;
  logic                  any_r, found_r;
  logic [D_W-1:0]        best_r;
  logic [IDX_W-1:0]      sel_idx_r;
  logic [COORD_BITS-1:0] sel_x_r, sel_y_r;

  // commit
  logic                  wr_req;
  logic [IDX_W-1:0]      wr_addr;
  logic [WORD_W-1:0]     wr_data;
  out_res_t              res;
  logic                  out_valid_r;
  out_res_t              out_data_r;

  gnpc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.commit && wr_req),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (scan_addr_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r  <= in_data.req_type;
      px_r   <= COORD_BITS'(in_data.point_x);
      py_r   <= COORD_BITS'(in_data.point_y);
      rank_r <= in_data.random_rank;
    end
  end

  // stage 0: address sweep
  assign rd_go = cmd.scan && (scan_addr_r < cnt_r);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      scan_addr_r <= '0;
    end else if (rd_go) begin
      scan_addr_r <= scan_addr_r + CNT_W'(1);
    end
    idx1_r <= scan_addr_r[IDX_W-1:0];
  end

  // stage 1: squared differences
  assign ru = rd_data[WORD_W-1];
  assign rx = rd_data[SQ_W-1:COORD_BITS];
  assign ry = rd_data[COORD_BITS-1:0];
  assign dx = (rx >= last_x_r) ? rx - last_x_r : last_x_r - rx;
  assign dy = (ry >= last_y_r) ? ry - last_y_r : last_y_r - ry;

  always_ff @(posedge clk) begin
    sqx_r  <= SQ_W'(dx) * SQ_W'(dx);
    sqy_r  <= SQ_W'(dy) * SQ_W'(dy);
    x2_r   <= rx;
    y2_r   <= ry;
    u2_r   <= ru;
    idx2_r <= idx1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= rd_go;
      v2_r <= v1_r;
    end
  end

  // stage 2: sum, compare and rank count
  assign dsum = D_W'(sqx_r) + D_W'(sqy_r);
  assign take = v2_r && !u2_r && (chain_r ? (!any_r || dsum < best_r) : !found_r);
  assign hit  = v2_r && !u2_r && !chain_r && !found_r && (seen_r == RK_W'(rank_r));

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      seen_r  <= '0;
      any_r   <= 1'b0;
      found_r <= 1'b0;
    end else if (v2_r && !u2_r) begin
      seen_r <= seen_r + RK_W'(1);
      any_r  <= 1'b1;
      if (hit) begin
        found_r <= 1'b1;
      end
    end
    if (take) begin
      best_r    <= dsum;
      sel_idx_r <= idx2_r;
      sel_x_r   <= x2_r;
      sel_y_r   <= y2_r;
    end
  end

  assign sts.scan_done = !(scan_addr_r < cnt_r) && !v1_r && !v2_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

  // result and state update
  always_comb begin
    res        = '0;
    res.status = STS_OK;
    wr_req     = 1'b0;
    wr_addr    = sel_idx_r;
    wr_data    = {1'b1, sel_x_r, sel_y_r};
    cnt_nxt    = cnt_r;
    chain_nxt  = chain_r;
    last_x_nxt = last_x_r;
    last_y_nxt = last_y_r;
    case (req_r)
      REQ_LOAD: begin
        if (cnt_r == CNT_W'(MAX_POINTS)) begin
          res.status = STS_FULL;
        end else begin
          wr_req           = 1'b1;
          wr_addr          = cnt_r[IDX_W-1:0];
          wr_data          = {1'b0, px_r, py_r};
          res.chosen_x     = XY_W'(px_r);
          res.chosen_y     = XY_W'(py_r);
          res.chosen_index = IDXO_W'(cnt_r);
          cnt_nxt          = cnt_r + CNT_W'(1);
        end
      end
      REQ_NEW: begin
        chain_nxt = 1'b0;
      end
      REQ_ADD: begin
        if (!any_r) begin
          res.status = STS_EMPTY;
        end else begin
          wr_req           = 1'b1;
          res.chosen_x     = XY_W'(sel_x_r);
          res.chosen_y     = XY_W'(sel_y_r);
          res.chosen_index = IDXO_W'(sel_idx_r);
          last_x_nxt       = sel_x_r;
          last_y_nxt       = sel_y_r;
          chain_nxt        = 1'b1;
        end
      end
      default: begin
        res.status = STS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      chain_r     <= 1'b0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      cnt_r       <= cnt_nxt;
      chain_r     <= chain_nxt;
      last_x_r    <= last_x_nxt;
      last_y_r    <= last_y_nxt;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hdl/greedy_nearest_point_chain_top.sv @@
// Sequence: a load, new-chain or other request goes from acceptance straight to
// the output register once it is free; an add request first scans the store,
// one stored point per cycle through a 3-stage read and distance pipeline.
// Throughput: one request at a time; the next request is taken the cycle after
// the previous result enters the output register.
// Reset: synchronous active-low rst_n empties the store, clears the chain.
// ----------------------------------------------------------------------------
// greedy_nearest_point_chain_top
// Point store that builds a chain by picking the nearest unused point; a chain's first point is picked by random rank.
// ----------------------------------------------------------------------------
module greedy_nearest_point_chain_top #(
  parameter int MAX_POINTS = 256,
  parameter int COORD_BITS = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gnpc_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output gnpc_pkg::out_res_t out_data
);
  import gnpc_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  gnpc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (in_data.req_type),
    .sts      (sts),
    .cmd      (cmd)
  );

  gnpc_dp #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ hdl/gnpc_checker.sv @@
// ----------------------------------------------------------------------------
// gnpc_checker
// Port-level checks for the greedy nearest point chain block.
// ----------------------------------------------------------------------------
module gnpc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input gnpc_pkg::in_req_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input gnpc_pkg::out_res_t out_data
);
  import gnpc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && !in_stall |=> in_stall)
    else $error("request taken while another is in progress");

  a_full_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STS_FULL || out_data.status == STS_EMPTY) |->
      out_data.chosen_x == '0 && out_data.chosen_y == '0 && out_data.chosen_index == '0)
    else $error("nonzero payload on failed request");

endmodule

bind greedy_nearest_point_chain_top gnpc_checker u_gnpc_checker (.*);
